### rtl/rpn_stack_evaluator_core_assert.svh
// ---------------------------------------------------------------------------
// RPN evaluator assertion macros
// Shared property forms for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef RPN_STACK_EVALUATOR_CORE_ASSERT_SVH
`define RPN_STACK_EVALUATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPN_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rpn check failed: same-cycle property");

// The consequent must hold in the cycle after the antecedent.
`define RPN_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rpn check failed: next-cycle property");

`endif

### rtl/rpn_pkg.sv
// ---------------------------------------------------------------------------
// RPN evaluator package
// Types, character codes and helpers shared by the evaluator modules.
// ---------------------------------------------------------------------------
package rpn_pkg;

	// Default number of stack entries.
	localparam int STACK_DEPTH_DEF = 16;

	// Operand width and number of divider iterations.
	localparam int DW = 32;

	// Character codes.
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_SEP     = 3'd1,
		ST_BADCHAR = 3'd2,
		ST_FEW     = 3'd3,
		ST_DIVZERO = 3'd4,
		ST_EMPTY   = 3'd5,
		ST_LEFT    = 3'd6,
		ST_DEEP    = 3'd7
	} status_t;

	// Arithmetic operations.
	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_EXEC,
		S_DIV,
		S_FIN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic        push;
		logic [3:0]  digit;
		logic        rd_en;
		logic        alu_wr;
		op_t         alu_op;
		logic        div_start;
		logic        div_wr;
		logic        out_load;
		status_t     out_status;
		logic        clear;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic lt2;
		logic empty;
		logic multi;
		logic top_zero;
		logic div_done;
		logic out_free;
	} dp_stat_t;

	// Whitespace that may stand between tokens.
	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
	endfunction

endpackage

### rtl/rpn_div.sv
// ---------------------------------------------------------------------------
// RPN signed divider
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle,
// quotient truncated toward zero.
// ---------------------------------------------------------------------------
module rpn_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [rpn_pkg::DW-1:0]  dividend,
	input  logic [rpn_pkg::DW-1:0]  divisor,
	output logic                    done,
	output logic [rpn_pkg::DW-1:0]  quotient
);
	import rpn_pkg::*;

	localparam int CNT_W = $clog2(DW);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    quo_q;
	logic [DW-1:0]    dvs_q;
	logic             neg_q;
	logic [DW:0]      trial;

	// Trial subtraction of the divisor from the shifted partial remainder.
	assign trial = {rem_q, quo_q[DW-1]} - {1'b0, dvs_q};

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand magnitudes and the shift of quotient and remainder.
	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor[DW-1] ? (DW'(0) - divisor) : divisor;
			quo_q <= dividend[DW-1] ? (DW'(0) - dividend) : dividend;
			rem_q <= '0;
			neg_q <= dividend[DW-1] ^ divisor[DW-1];
		end else if (busy_q) begin
			if (!trial[DW]) begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DW-2:0], quo_q[DW-1]};
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	// Restore the sign; the most negative value over minus one stays as it is.
	assign done     = done_q;
	assign quotient = neg_q ? (DW'(0) - quo_q) : quo_q;

endmodule

### rtl/rpn_dpath.sv
// ---------------------------------------------------------------------------
// RPN datapath
// Operand stack with the top entry in a register, arithmetic unit,
// divider and the output register.
// ---------------------------------------------------------------------------
module rpn_dpath #(
	parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rpn_pkg::dp_cmd_t        cmd,
	output rpn_pkg::dp_stat_t       stat,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [rpn_pkg::DW-1:0]  m_tdata,
	output logic [2:0]              m_tuser
);
	import rpn_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	// Entries below the top of the stack; the top lives in top_q.
	logic [DW-1:0] mem [STACK_DEPTH];

	logic [CW-1:0] count_q;
	logic [DW-1:0] top_q;
	logic [DW-1:0] rd_q;
	logic [CW-1:0] count_m1;
	logic [CW-1:0] count_m2;
	logic [DW-1:0] alu_res;
	logic          div_done;
	logic [DW-1:0] div_quo;
	logic          m_valid_q;
	logic [DW-1:0] m_data_q;
	logic [2:0]    m_user_q;

	assign count_m1 = count_q - CW'(1);
	assign count_m2 = count_q - CW'(2);

	// Stack memory: the old top moves down on a push, the left operand is read.
	always_ff @(posedge clk) begin
		if (cmd.push && (count_q != '0)) begin
			mem[count_m1[AW-1:0]] <= top_q;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[count_m2[AW-1:0]];
		end
	end

	// Add, subtract and multiply, all wrapping at the operand width.
	always_comb begin
		case (cmd.alu_op)
			OP_ADD:  alu_res = rd_q + top_q;
			OP_SUB:  alu_res = rd_q - top_q;
			OP_MUL:  alu_res = rd_q * top_q;
			default: alu_res = rd_q;
		endcase
	end

	rpn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (rd_q),
		.divisor  (top_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Top of stack.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			top_q <= {{(DW-4){1'b0}}, cmd.digit};
		end else if (cmd.alu_wr) begin
			top_q <= alu_res;
		end else if (cmd.div_wr) begin
			top_q <= div_quo;
		end
	end

	// Fill count of the stack.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.push) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.alu_wr || cmd.div_wr) begin
			count_q <= count_m1;
		end
	end

	// Output register: the result waits here until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_data_q <= (cmd.out_status == ST_OK) ? top_q : '0;
			m_user_q <= cmd.out_status;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	// Status for the controller.
	assign stat.full     = (count_q == CW'(STACK_DEPTH));
	assign stat.lt2      = (count_q < CW'(2));
	assign stat.empty    = (count_q == '0);
	assign stat.multi    = (count_q > CW'(1));
	assign stat.top_zero = (top_q == '0);
	assign stat.div_done = div_done;
	assign stat.out_free = !m_valid_q || m_tready;

endmodule

### rtl/rpn_ctrl.sv
// ---------------------------------------------------------------------------
// RPN controller
// Tokeniser, error latch and sequencer of the stack operations.
// ---------------------------------------------------------------------------
module rpn_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,
	input  logic               s_tlast,
	output rpn_pkg::dp_cmd_t   cmd,
	input  rpn_pkg::dp_stat_t  stat
);
	import rpn_pkg::*;

	state_t     state_q, state_d;
	logic [7:0] char_q;
	logic       last_q;
	logic       pend_v_q, pend_v_d;
	logic [7:0] pend_tok_q, pend_tok_d;
	status_t    err_q, err_d;
	op_t        op_q, op_d;
	logic       do_exec;
	logic [7:0] tok;
	state_t     state_end;

	// State and token registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pend_v_q   <= 1'b0;
			pend_tok_q <= '0;
			err_q      <= ST_OK;
			last_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			pend_v_q   <= pend_v_d;
			pend_tok_q <= pend_tok_d;
			err_q      <= err_d;
			if (s_tvalid && s_tready) begin
				last_q <= s_tlast;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_q <= s_tdata;
		end
		op_q <= op_d;
	end

	// Where a request goes once its stack work is finished.
	assign state_end = last_q ? S_FIN : S_IDLE;

	// Next state and commands.
	always_comb begin
		state_d    = state_q;
		pend_v_d   = pend_v_q;
		pend_tok_d = pend_tok_q;
		err_d      = err_q;
		op_d       = op_q;
		cmd        = '0;
		cmd.alu_op = op_q;
		s_tready   = 1'b0;
		do_exec    = 1'b0;
		tok        = pend_v_q ? pend_tok_q : char_q;

		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = S_DECODE;
				end
			end

			S_DECODE: begin
				state_d = state_end;
				// A held token needs a space after it; otherwise start a new token.
				if (err_q == ST_OK) begin
					if (pend_v_q) begin
						pend_v_d = 1'b0;
						if (char_q == CH_SPACE) begin
							do_exec = 1'b1;
						end else begin
							err_d = ST_SEP;
						end
					end else if (!is_blank(char_q)) begin
						if (last_q) begin
							do_exec = 1'b1;
						end else begin
							pend_v_d   = 1'b1;
							pend_tok_d = char_q;
						end
					end
				end
				// Judge the token and issue its stack work.
				if (do_exec) begin
					if (tok inside {[CH_ZERO:CH_NINE]}) begin
						if (stat.full) begin
							err_d = ST_DEEP;
						end else begin
							cmd.push  = 1'b1;
							cmd.digit = tok[3:0];
						end
					end else if (!(tok == CH_PLUS || tok == CH_MINUS ||
						tok == CH_STAR || tok == CH_SLASH)) begin
						err_d = ST_BADCHAR;
					end else if (stat.lt2) begin
						err_d = ST_FEW;
					end else if ((tok == CH_SLASH) && stat.top_zero) begin
						err_d = ST_DIVZERO;
					end else begin
						cmd.rd_en = 1'b1;
						state_d   = S_EXEC;
						case (tok)
							CH_PLUS:  op_d = OP_ADD;
							CH_MINUS: op_d = OP_SUB;
							CH_STAR:  op_d = OP_MUL;
							default:  op_d = OP_DIV;
						endcase
					end
				end
			end

			S_EXEC: begin
				if (op_q == OP_DIV) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					cmd.alu_wr = 1'b1;
					state_d    = state_end;
				end
			end

			S_DIV: begin
				if (stat.div_done) begin
					cmd.div_wr = 1'b1;
					state_d    = state_end;
				end
			end

			S_FIN: begin
				// Report the result, empty the stack and clear the error and any held token.
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.clear    = 1'b1;
					if (err_q != ST_OK) begin
						cmd.out_status = err_q;
					end else if (stat.empty) begin
						cmd.out_status = ST_EMPTY;
					end else if (stat.multi) begin
						cmd.out_status = ST_LEFT;
					end else begin
						cmd.out_status = ST_OK;
					end
					err_d      = ST_OK;
					pend_v_d   = 1'b0;
					pend_tok_d = '0;
					state_d    = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### rtl/rpn_stack_evaluator_core.sv
// ---------------------------------------------------------------------------
// RPN stack evaluator core
// Evaluates a reverse Polish expression, one ASCII character per request.
//
// Input channel s_*: one character per request, s_tlast marks the final one.
// Output channel m_*: one result per expression, sent after the final
// character; m_tdata carries the value, m_tuser the status code.
// Each character is taken in the idle state and decoded; + - and * add an
// execute step, and / adds the radix-2 divider, which retires one quotient
// bit per cycle. The final character adds a step that loads the output
// register, and the result is offered in the cycle after it is loaded.
// The result waits in the output register while the receiver stalls; the
// next expression is taken in meanwhile and only its final step waits.
// Reset empties the stack, clears any held token and error, and drops a
// result that has not been taken. No clearing pass is needed.
// ---------------------------------------------------------------------------
`include "rpn_stack_evaluator_core_assert.svh"

module rpn_stack_evaluator_core #(
	parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_in
	input  logic        s_tlast,   // last_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] value
	output logic [2:0]  m_tuser    // [2:0] status
);
	import rpn_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	rpn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.cmd      (cmd),
		.stat     (stat)
	);

	rpn_dpath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// No stack work is commanded while a new request may be taken.
	`RPN_ASSERT_SAME(a_idle_no_work, s_tready, !(cmd.push || cmd.rd_en || cmd.alu_wr || cmd.div_wr))
	// A result is loaded only when the output register is free.
	`RPN_ASSERT_SAME(a_load_free, cmd.out_load, stat.out_free)
	// The quotient is written back only when the divider has finished.
	`RPN_ASSERT_SAME(a_div_wr_done, cmd.div_wr, stat.div_done)
	// A loaded result is offered in the following cycle.
	`RPN_ASSERT_NEXT(a_load_valid, cmd.out_load, m_tvalid)

endmodule
